// ----- hdl/tvm_pkg.sv -----
// Shared types and constants of the ternary weight matrix-vector block.
`timescale 1ns / 1ps

package tvm_pkg;

    // Fixed field widths of the request and result items.
    localparam int OPCODE_W = 1;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 16;
    localparam int VLEN_W   = 11;
    localparam int ROWS_W   = 16;
    localparam int OUT_W    = 52;

    // Default depth of the activation store and the weight row buffer.
    localparam int MAX_COLUMNS_DEF = 1024;

    // Request opcodes.
    localparam logic [OPCODE_W-1:0] OP_ACTIVATION = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_WEIGHT     = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 1'b1;

    // Configuration write data width.
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] element_value;
    } tvm_in_t;

    typedef struct packed {
        logic [ROWS_W-1:0]       row_index;
        logic signed [OUT_W-1:0] out_value;
        logic                    last_row;
    } tvm_out_t;

endpackage

// ----- hdl/tvm_div.sv -----
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tvm_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // The divisor is never zero here, so the remainder stays below it.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/ternary_weight_matvec.sv -----
// Top level of the absmean ternary weight matrix-vector block.
`timescale 1ns / 1ps

// Usage. Requests arrive on the item channel (item_valid, item_stall, item).
// An activation request (opcode 0) writes the activation store at its column,
// a weight request (opcode 1) writes the weight row buffer at its column. The
// weight at column d-1 closes the row, where d is vector_length held within
// 1..MAX_COLUMNS. The block then sums the absolute weights into S, walks the
// row again to ternarize each weight and add or subtract its activation,
// multiplies the sum by S and divides by d, and offers one result on the
// result channel (result_valid, result_stall, result).
// Flow: requests that do not close a row are taken back to back while the
// block is idle. A request that closes a row holds item_stall high until
// its result is in the output register. The two walks over the buffers
// read one entry per cycle through the memory read ports, and the
// bit-serial divider then produces the quotient.
// A finished result waits in the output register while the receiver stalls;
// the block keeps taking requests, and holds the next result until the
// register is free. Configuration writes (cfg_valid, cfg_ready) are taken in
// any cycle and are meant for idle periods. Reset clears the row counter and
// loads vector_length 1024 and row_count 1; the stores are undefined until
// written.
module ternary_weight_matvec #(
    parameter int MAX_COLUMNS = tvm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  tvm_pkg::tvm_in_t                   item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output tvm_pkg::tvm_out_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tvm_pkg::*;

    // Widths that follow from the store depth.
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int SUM_W  = CNT_W + 15;
    localparam int ACC_W  = CNT_W + 16;
    localparam int LHS_W  = CNT_W + 18;
    localparam int PROD_W = ACC_W + SUM_W + 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DVS  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]              state_reg,    state_next;
    logic [VLEN_W-1:0]       vlen_reg,     vlen_next;
    logic [ROWS_W-1:0]       rows_reg,     rows_next;
    logic [ROWS_W-1:0]       rowcnt_reg,   rowcnt_next;
    logic [CNT_W-1:0]        d_reg,        d_next;
    logic [CNT_W-1:0]        rd_addr_reg,  rd_addr_next;
    logic                    rd_vld_reg,   rd_vld_next;
    logic [SUM_W-1:0]        sum_reg,      sum_next;
    logic signed [ACC_W-1:0] acc_reg,      acc_next;
    logic signed [PROD_W-1:0] prod_reg,    prod_next;
    logic                    neg_reg,      neg_next;
    logic                    out_vld_reg,  out_vld_next;
    tvm_out_t                out_reg,      out_next;

    logic [CNT_W-1:0]        d_eff;
    logic                    accept;
    logic                    col_ok;
    logic                    row_done;
    logic                    issue;
    logic                    pass_end;
    logic                    out_free;
    logic                    out_load;
    logic                    is_last;

    logic signed [VAL_W-1:0] act_mem [MAX_COLUMNS];
    logic signed [VAL_W-1:0] wgt_mem [MAX_COLUMNS];
    logic signed [VAL_W-1:0] act_rdata;
    logic signed [VAL_W-1:0] wgt_rdata;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;

    logic [VAL_W:0]          w_wide;
    logic [VAL_W:0]          w_abs;
    logic signed [LHS_W-1:0] lhs;
    logic signed [LHS_W-1:0] s_ext;
    logic signed [ACC_W-1:0] act_ext;
    logic [PROD_W-1:0]       prod_mag;
    logic                    div_start;
    logic                    div_done;
    logic [PROD_W-1:0]       div_quo;
    logic signed [PROD_W-1:0] quo_signed;

    // Configuration port: always ready; to be written only while idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    // Effective row length: zero acts as one, and it never exceeds the store.
    always_comb
    begin
        if (vlen_reg == '0)
        begin
            d_eff = CNT_W'(1);
        end
        else if (int'(vlen_reg) > MAX_COLUMNS)
        begin
            d_eff = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            d_eff = CNT_W'(vlen_reg);
        end
    end

    // A request is taken only while the sequencer is idle.
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign col_ok     = int'(item.column) < MAX_COLUMNS;
    assign row_done   = accept && col_ok && (item.opcode == OP_WEIGHT)
                        && ((int'(item.column) + 1) == int'(d_eff));
    assign wr_addr    = ADDR_W'(item.column);

    // Both memories share one read address that walks the row.
    assign issue    = (rd_addr_reg < d_reg);
    assign rd_addr  = ADDR_W'(rd_addr_reg);
    assign pass_end = !issue && !rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (accept && col_ok && (item.opcode == OP_ACTIVATION))
        begin
            act_mem[wr_addr] <= item.element_value;
        end
        act_rdata <= act_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && col_ok && (item.opcode == OP_WEIGHT))
        begin
            wgt_mem[wr_addr] <= item.element_value;
        end
        wgt_rdata <= wgt_mem[rd_addr];
    end

    // Datapath of one walk step: the absolute weight for the sum pass, and
    // the comparison of 2*d*w against S for the ternarizing pass.
    assign w_wide  = (VAL_W + 1)'(wgt_rdata);
    assign w_abs   = w_wide[VAL_W] ? (VAL_W + 1)'(-w_wide) : w_wide;
    assign lhs     = LHS_W'(signed'({1'b0, d_reg, 1'b0})) * LHS_W'(wgt_rdata);
    assign s_ext   = signed'(LHS_W'(sum_reg));
    assign act_ext = ACC_W'(act_rdata);

    assign prod_mag   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign div_start  = (state_reg == ST_DVS);
    assign quo_signed = neg_reg ? -signed'(div_quo) : signed'(div_quo);

    tvm_div #(
        .NUM_W (PROD_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (prod_mag),
        .denom    (d_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // The output register frees when its result is taken.
    assign out_free = !out_vld_reg || !result_stall;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign is_last  = ((ROWS_W + 1)'(rowcnt_reg) + (ROWS_W + 1)'(1))
                      >= (ROWS_W + 1)'(rows_reg);

    always_comb
    begin
        state_next   = state_reg;
        vlen_next    = vlen_reg;
        rows_next    = rows_reg;
        rowcnt_next  = rowcnt_reg;
        d_next       = d_reg;
        rd_addr_next = rd_addr_reg;
        rd_vld_next  = 1'b0;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        out_vld_next = out_vld_reg && result_stall;
        out_next     = out_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VECTOR_LENGTH: vlen_next = VLEN_W'(cfg_data);
                CFG_ROW_COUNT:     rows_next = ROWS_W'(cfg_data);
                default:           vlen_next = vlen_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (row_done)
                begin
                    d_next       = d_eff;
                    rd_addr_next = '0;
                    sum_next     = '0;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                    rd_vld_next  = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    sum_next = sum_reg + SUM_W'(w_abs);
                end
                if (pass_end)
                begin
                    rd_addr_next = '0;
                    acc_next     = '0;
                    state_next   = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + CNT_W'(1);
                    rd_vld_next  = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (lhs > s_ext)
                    begin
                        acc_next = acc_reg + act_ext;
                    end
                    else if (lhs < -s_ext)
                    begin
                        acc_next = acc_reg - act_ext;
                    end
                end
                if (pass_end)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(acc_reg) * PROD_W'(signed'({1'b0, sum_reg}));
                state_next = ST_DVS;
            end
            ST_DVS:
            begin
                neg_next   = prod_reg[PROD_W-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_vld_next       = 1'b1;
                    out_next.row_index = rowcnt_reg;
                    out_next.out_value = OUT_W'(quo_signed);
                    out_next.last_row  = is_last;
                    rowcnt_next        = is_last ? '0 : rowcnt_reg + ROWS_W'(1);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vlen_reg    <= VLEN_W'(1024);
            rows_reg    <= ROWS_W'(1);
            rowcnt_reg  <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vlen_reg    <= vlen_next;
            rows_reg    <= rows_next;
            rowcnt_reg  <= rowcnt_next;
            rd_addr_reg <= rd_addr_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        sum_reg  <= sum_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // The divider reports completion only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // The walk address never runs past the row length.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUM) || (state_reg == ST_ACC)) |-> (rd_addr_reg <= d_reg))
        else $error("row walk address beyond the row length");

    // A finished row always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result_valid && (state_reg == ST_IDLE)))
        else $error("finished row was not loaded into the output register");

    // The last row of a pass returns the row counter to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (rowcnt_reg == '0))
        else $error("row counter did not wrap after the last row");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the ternary weight matrix-vector block.
`timescale 1ns / 1ps

module tb;
    import tvm_pkg::*;

    localparam int DEPTH       = MAX_COLUMNS_DEF;
    localparam int FILL_COLS   = 64;
    localparam int SETTLE      = 20;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 105;
    localparam int DRAIN_LIMIT = 200000;
    localparam int TIMEOUT_NS  = 500_000_000;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    tvm_in_t   item;
    logic      result_valid;
    logic      result_stall;
    tvm_out_t  result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the block: both stores, the row counter and both registers.
    logic signed [VAL_W-1:0] act_mem [DEPTH];
    logic signed [VAL_W-1:0] wt_mem [DEPTH];
    int unsigned             row_ctr;
    logic [VLEN_W-1:0]       vlen_reg;
    logic [ROWS_W-1:0]       rows_reg;

    // Rows whose result has been predicted but not yet seen on the result port.
    tvm_out_t pending_rows[$];

    // While set, neither side inserts idle cycles.
    bit steady_traffic;

    int requests_sent;
    int rows_checked;
    int last_rows_seen;
    int zero_rows_seen;
    int cfg_writes;
    int failures;

    ternary_weight_matvec DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hung block must still end the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // Most gaps are zero or short, a few are long.
    function automatic int idle_cycles();
        int r;
        if (steady_traffic)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Element values: extremes now and then, many small ones so that weights of
    // similar size land on both sides of the threshold, the rest full range.
    function automatic logic signed [VAL_W-1:0] rand_value();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 4))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                3:       return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
        if (r < 50)
            v = int'($urandom_range(0, 511)) - 256;
        else
            v = $urandom();
        return v[VAL_W-1:0];
    endfunction

    // Vector length held within 1..DEPTH, as the block uses it.
    function automatic int unsigned effective_length();
        if (vlen_reg == '0)
            return 1;
        if (vlen_reg > DEPTH)
            return DEPTH;
        return vlen_reg;
    endfunction

    // Sum of absolute weights S, then the activations summed under the ternary
    // signs, then acc * S / d truncated toward zero.
    function automatic longint ternary_row_value(input int unsigned d);
        longint s;
        longint acc;
        longint w;
        longint two_d;
        int     j;
        s     = 0;
        acc   = 0;
        two_d = 2 * longint'(d);
        for (j = 0; j < d; j++)
        begin
            w = longint'(wt_mem[j]);
            s += (w < 0) ? -w : w;
        end
        for (j = 0; j < d; j++)
        begin
            w = two_d * longint'(wt_mem[j]);
            if (w > s)
                acc += longint'(act_mem[j]);
            else if (w < -s)
                acc -= longint'(act_mem[j]);
        end
        return (acc * s) / longint'(d);
    endfunction

    // Apply one accepted request to the shadow state and predict its result.
    task automatic absorb_request(input tvm_in_t req);
        tvm_out_t    row;
        int unsigned d;
        longint      value;
        bit          is_last;
        if (req.opcode == OP_ACTIVATION)
        begin
            act_mem[req.column] = req.element_value;
        end
        else
        begin
            wt_mem[req.column] = req.element_value;
            d = effective_length();
            if (req.column == d - 1)
            begin
                value            = ternary_row_value(d);
                is_last          = (row_ctr + 1) >= rows_reg;
                row.row_index    = row_ctr[ROWS_W-1:0];
                row.out_value    = value[OUT_W-1:0];
                row.last_row     = is_last;
                pending_rows.push_back(row);
                row_ctr = is_last ? 0 : ((row_ctr + 1) & 32'hFFFF);
            end
        end
    endtask

    function automatic void report_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t MISMATCH: %s", $time, msg);
    endfunction

    // Drive one request and hold it until the block takes it.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input int col,
                                input logic signed [VAL_W-1:0] val);
        tvm_in_t req;
        int      gap;
        req.opcode        = op;
        req.column        = col[COL_W-1:0];
        req.element_value = val;
        item_valid <= 1'b1;
        item       <= req;
        do
            @(posedge clk);
        while (item_stall);
        absorb_request(req);
        requests_sent++;
        gap = idle_cycles();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, let every predicted row arrive, then let the block settle.
    task automatic wait_results(input int settle);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_VECTOR_LENGTH)
            vlen_reg = data[VLEN_W-1:0];
        else
            rows_reg = data;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One row: either every weight below the closing column in shuffled order,
    // or a few scattered updates over what the buffer already holds. Columns
    // at or past d are stored but close nothing. Some rows are abandoned before
    // the closing weight.
    task automatic send_row(input int unsigned d);
        int cols[$];
        int n;
        int j;
        int k;
        int tmp;
        int col;
        if (d <= 64 && $urandom_range(0, 3) != 0)
        begin
            for (j = 0; j < d - 1; j++)
                cols.push_back(j);
            for (j = cols.size() - 1; j > 0; j--)
            begin
                k       = $urandom_range(0, j);
                tmp     = cols[j];
                cols[j] = cols[k];
                cols[k] = tmp;
            end
        end
        else
        begin
            n = $urandom_range(0, 6);
            for (j = 0; j < n; j++)
            begin
                col = $urandom_range(0, DEPTH - 1);
                if (col == d - 1)
                    col = (col + 1) % DEPTH;
                cols.push_back(col);
            end
        end
        foreach (cols[i])
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                col = ($urandom_range(0, 9) < 7) ? $urandom_range(0, d - 1)
                                                 : $urandom_range(0, DEPTH - 1);
                send_request(OP_ACTIVATION, col, rand_value());
            end
            send_request(OP_WEIGHT, cols[i], rand_value());
        end
        if ($urandom_range(0, 9) != 0)
            send_request(OP_WEIGHT, d - 1, rand_value());
    endtask

    // Under the reset length of 1024 columns, fill the first FILL_COLS entries
    // of both stores; none of these weights reaches the closing column, so no
    // result comes back. A length of FILL_COLS then lets one more weight close
    // the row. Later rows never reach past these entries.
    task automatic test_prefill_row();
        int j;
        steady_traffic = 1'b1;
        send_request(OP_ACTIVATION, 0, 16'sh7FFF);
        send_request(OP_ACTIVATION, 1, 16'sh8000);
        for (j = 2; j < FILL_COLS; j++)
            send_request(OP_ACTIVATION, j, rand_value());
        send_request(OP_WEIGHT, 0, 16'sh8000);
        send_request(OP_WEIGHT, 1, 16'sh7FFF);
        for (j = 2; j < FILL_COLS; j++)
            send_request(OP_WEIGHT, j, rand_value());
        steady_traffic = 1'b0;
        wait_results(SETTLE);
        write_register(CFG_VECTOR_LENGTH, 16'(FILL_COLS));
        send_request(OP_WEIGHT, FILL_COLS - 1, rand_value());
        wait_results(SETTLE);
    endtask

    // Threshold ties, an all-zero row, single-column extremes and the way
    // out-of-range lengths are held.
    task automatic test_sign_thresholds();
        int j;
        // With weights 1 and 3 over two columns, 2*d*w meets S exactly for the
        // first weight, which must become zero; the same holds with both negated.
        write_register(CFG_VECTOR_LENGTH, 16'd2);
        write_register(CFG_ROW_COUNT, 16'd1);
        send_request(OP_WEIGHT, 0, 16'sd1);
        send_request(OP_WEIGHT, 1, 16'sd3);
        send_request(OP_WEIGHT, 0, -16'sd1);
        send_request(OP_WEIGHT, 1, -16'sd3);

        // All weights zero: S is zero and so is the result.
        wait_results(SETTLE);
        write_register(CFG_VECTOR_LENGTH, 16'd3);
        for (j = 0; j < 3; j++)
            send_request(OP_WEIGHT, j, 16'sd0);

        // One column with the most negative and most positive values.
        wait_results(SETTLE);
        write_register(CFG_VECTOR_LENGTH, 16'd1);
        send_request(OP_ACTIVATION, 0, 16'sh8000);
        send_request(OP_WEIGHT, 0, 16'sh8000);
        send_request(OP_ACTIVATION, 0, 16'sh7FFF);
        send_request(OP_WEIGHT, 0, 16'sh7FFF);
        send_request(OP_WEIGHT, 0, 16'sd0);

        // A length of zero behaves as one column.
        wait_results(SETTLE);
        write_register(CFG_VECTOR_LENGTH, 16'd0);
        send_request(OP_WEIGHT, 0, rand_value());

        // A length past the store depth is held at the depth, so a weight
        // inside the row only updates the buffer.
        wait_results(SETTLE);
        write_register(CFG_VECTOR_LENGTH, 16'd2047);
        send_request(OP_WEIGHT, 1000, rand_value());

        // Only the low bits of the write data reach the length register.
        wait_results(SETTLE);
        write_register(CFG_VECTOR_LENGTH, 16'hF802);
        send_request(OP_WEIGHT, 1, rand_value());
        wait_results(SETTLE);
    endtask

    // Row index wrap, a row count of zero and the largest row count. The row
    // counter carries across register writes.
    task automatic test_row_counting();
        int j;
        write_register(CFG_VECTOR_LENGTH, 16'd1);
        write_register(CFG_ROW_COUNT, 16'd3);
        for (j = 0; j < 4; j++)
            send_request(OP_WEIGHT, 0, rand_value());
        wait_results(SETTLE);
        write_register(CFG_ROW_COUNT, 16'd0);
        for (j = 0; j < 2; j++)
            send_request(OP_WEIGHT, 0, rand_value());
        wait_results(SETTLE);
        write_register(CFG_ROW_COUNT, 16'hFFFF);
        for (j = 0; j < 2; j++)
            send_request(OP_WEIGHT, 0, rand_value());
        wait_results(SETTLE);
    endtask

    // Random rows over a series of settings, the widest filled length among them.
    task automatic test_random_rows();
        int unsigned lens [PHASES] = '{1, 5, 16, 3, FILL_COLS, 0, 2};
        int unsigned rows [PHASES] = '{1, 4, 65535, 0, 3, 0, 2};
        int unsigned d_set;
        int unsigned r_set;
        int          start;
        int          p;
        for (p = 0; p < PHASES; p++)
        begin
            d_set = lens[p];
            r_set = rows[p];
            if (p == 5)
            begin
                d_set = $urandom_range(2, 40);
                r_set = $urandom_range(1, 6);
            end
            wait_results(SETTLE);
            write_register(CFG_VECTOR_LENGTH, d_set[CFG_DATA_W-1:0]);
            write_register(CFG_ROW_COUNT, r_set[CFG_DATA_W-1:0]);
            steady_traffic = (p == 2);
            start = requests_sent;
            while (requests_sent - start < PHASE_ITEMS)
            begin
                send_row(effective_length());
                // Now and then the sender holds off until every row is back.
                if ($urandom_range(0, 19) == 0)
                    wait_results(0);
            end
        end
        steady_traffic = 1'b0;
        wait_results(SETTLE);
    endtask

    // Receiver back-pressure: stall runs of random length between open runs.
    initial
    begin
        int run;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = idle_cycles();
            if (run > 0)
            begin
                result_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Every result taken by the receiver is matched against the oldest prediction.
    initial
    begin
        tvm_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
            begin
                if (pending_rows.size() == 0)
                begin
                    report_failure($sformatf("unexpected result index %0d value %0d last %0b",
                                             result.row_index, result.out_value,
                                             result.last_row));
                end
                else
                begin
                    want = pending_rows.pop_front();
                    rows_checked++;
                    if (result !== want)
                        report_failure($sformatf(
                            "expected index %0d value %0d last %0b, got index %0d value %0d last %0b",
                            want.row_index, want.out_value, want.last_row,
                            result.row_index, result.out_value, result.last_row));
                    else
                    begin
                        if (want.last_row)
                            last_rows_seen++;
                        if (want.out_value == '0)
                            zero_rows_seen++;
                    end
                end
            end
        end
    end

    initial
    begin
        int spins;
        int leftover;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        row_ctr        = 0;
        vlen_reg       = VLEN_W'(DEPTH);
        rows_reg       = 16'd1;
        steady_traffic = 1'b0;
        requests_sent  = 0;
        rows_checked   = 0;
        last_rows_seen = 0;
        zero_rows_seen = 0;
        cfg_writes     = 0;
        failures       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prefill_row();
        test_sign_thresholds();
        test_row_counting();
        test_random_rows();

        // Give any late row a bounded chance to arrive, then count what is left.
        spins = 0;
        while (pending_rows.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (50) @(posedge clk);
        leftover = pending_rows.size();
        if (leftover != 0)
            report_failure($sformatf("%0d predicted rows never arrived", leftover));

        $display("Summary: %0d requests, %0d rows checked (%0d last, %0d zero-valued).",
                 requests_sent, rows_checked, last_rows_seen, zero_rows_seen);
        $display("Summary: %0d register writes, lengths 0 to 2047, row counts 0 to 65535.",
                 cfg_writes);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
